>>> rtl/isfd_pkg.sv
// Shared types and constants for the IMU serial frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package isfd_pkg;

    localparam logic [7:0] SYNC_RESET = 8'h55;

    localparam logic [7:0] TYPE_ACCEL = 8'h51;
    localparam logic [7:0] TYPE_RATE  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    localparam int          STORE_DEPTH = 9;
    localparam logic [3:0]  POS_SYNC    = 4'd0;
    localparam logic [3:0]  POS_FIRST   = 4'd1;
    localparam logic [3:0]  POS_STORED  = 4'd9;
    localparam logic [3:0]  POS_CHECK   = 4'd10;

    localparam logic [1:0] KIND_ACCEL = 2'd0;
    localparam logic [1:0] KIND_RATE  = 2'd1;
    localparam logic [1:0] KIND_ANGLE = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic [6:0] MUL_ACCEL = 7'd1;
    localparam logic [6:0] MUL_RATE  = 7'd125;
    localparam logic [6:0] MUL_ANGLE = 7'd45;

    // 771 / 2^16 sits just below 1/85; one correction step restores the exact quotient.
    localparam logic [9:0]         TEMP_RECIP  = 10'd771;
    localparam logic [6:0]         TEMP_DIV    = 7'd85;
    localparam logic signed [16:0] TEMP_OFFSET = 17'sd9280;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic signed [15:0] raw_z;
        logic signed [15:0] raw_t;
    } frame_t;

    typedef struct packed {
        logic signed [16:0] temperature;
        logic signed [22:0] value_z;
        logic signed [22:0] value_y;
        logic signed [22:0] value_x;
        logic [1:0]         frame_kind;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/isfd_front.sv
// Front end: tracks the frame position, collects frame bytes and classifies finished frames.
`timescale 1ns / 1ps
`default_nettype none

module isfd_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [7:0]      in_byte,
    input  wire logic            sync_byte_we,
    input  wire logic [7:0]      sync_byte_wdata,
    input  wire logic            queue_full,
    output logic                 push_valid,
    output isfd_pkg::frame_t     push_data
);

    logic [7:0] sync_reg;
    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic [7:0] store_reg [isfd_pkg::STORE_DEPTH];
    logic [3:0] store_idx;
    logic       store_we;
    logic       accept;
    logic       frame_done;
    logic [1:0] kind;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign store_idx = pos_reg - isfd_pkg::POS_FIRST;

    always_comb
    begin
        pos_next   = pos_reg;
        store_we   = 1'b0;
        frame_done = 1'b0;
        case (pos_reg) inside
            [isfd_pkg::POS_FIRST:isfd_pkg::POS_STORED]:
            begin
                store_we = 1'b1;
                pos_next = pos_reg + 4'd1;
            end
            isfd_pkg::POS_CHECK:
            begin
                frame_done = 1'b1;
                pos_next   = isfd_pkg::POS_SYNC;
            end
            default:
            begin
                pos_next = (in_byte == sync_reg) ? isfd_pkg::POS_FIRST : isfd_pkg::POS_SYNC;
            end
        endcase
    end

    always_comb
    begin
        case (store_reg[0])
            isfd_pkg::TYPE_ACCEL: kind = isfd_pkg::KIND_ACCEL;
            isfd_pkg::TYPE_RATE:  kind = isfd_pkg::KIND_RATE;
            isfd_pkg::TYPE_ANGLE: kind = isfd_pkg::KIND_ANGLE;
            default:              kind = isfd_pkg::KIND_NONE;
        endcase
    end

    assign push_valid      = accept && frame_done && (kind != isfd_pkg::KIND_NONE);
    assign push_data.kind  = kind;
    assign push_data.raw_x = {store_reg[2], store_reg[1]};
    assign push_data.raw_y = {store_reg[4], store_reg[3]};
    assign push_data.raw_z = {store_reg[6], store_reg[5]};
    assign push_data.raw_t = {store_reg[8], store_reg[7]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= isfd_pkg::SYNC_RESET;
            pos_reg  <= isfd_pkg::POS_SYNC;
        end
        else
        begin
            if (sync_byte_we)
            begin
                sync_reg <= sync_byte_wdata;
            end
            if (accept)
            begin
                pos_reg <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && store_we)
        begin
            store_reg[store_idx] <= in_byte;
        end
    end

endmodule

`default_nettype wire

>>> rtl/isfd_queue.sv
// Short queue of classified frames between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module isfd_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire isfd_pkg::frame_t  push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   pop_valid,
    output isfd_pkg::frame_t       pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    isfd_pkg::frame_t  entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full      = (count_reg == CNT_FULL);
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full || pop)
        else $error("Frame pushed into a full queue.");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> pop_valid)
        else $error("Frame popped from an empty queue.");

endmodule

`default_nettype wire

>>> rtl/isfd_back.sv
// Back end: scales axis values and temperature in two stages and holds the output register.
`timescale 1ns / 1ps
`default_nettype none

module isfd_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire isfd_pkg::frame_t  q_data,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output isfd_pkg::result_t      out_data
);

    logic               s1_valid_reg;
    logic [1:0]         s1_kind_reg;
    logic signed [22:0] s1_x_reg;
    logic signed [22:0] s1_y_reg;
    logic signed [22:0] s1_z_reg;
    logic               s1_neg_reg;
    logic [21:0]        s1_mag_reg;
    logic [31:0]        s1_prod_reg;

    logic               out_valid_reg;
    isfd_pkg::result_t  out_reg;

    logic               out_adv;
    logic               s1_load;
    logic [6:0]         mul;
    logic signed [7:0]  mul_s;
    logic signed [23:0] prod_x;
    logic signed [23:0] prod_y;
    logic signed [23:0] prod_z;
    logic signed [16:0] t_abs;
    logic [21:0]        t_mag;
    logic [31:0]        t_prod;

    logic [15:0]        q0;
    logic [21:0]        rem;
    logic [15:0]        quot;
    logic signed [16:0] quot_s;
    logic signed [16:0] temp;

    assign out_adv = !out_valid_reg || out_ready;
    assign s1_load = !s1_valid_reg || out_adv;
    assign q_pop   = q_valid && s1_load;

    always_comb
    begin
        case (q_data.kind)
            isfd_pkg::KIND_RATE:  mul = isfd_pkg::MUL_RATE;
            isfd_pkg::KIND_ANGLE: mul = isfd_pkg::MUL_ANGLE;
            default:              mul = isfd_pkg::MUL_ACCEL;
        endcase
    end

    assign mul_s  = $signed({1'b0, mul});
    assign prod_x = q_data.raw_x * mul_s;
    assign prod_y = q_data.raw_y * mul_s;
    assign prod_z = q_data.raw_z * mul_s;

    assign t_abs  = q_data.raw_t[15] ? -17'(q_data.raw_t) : 17'(q_data.raw_t);
    assign t_mag  = {t_abs[15:0], 6'b0};
    assign t_prod = 32'(t_mag) * 32'(isfd_pkg::TEMP_RECIP);

    assign q0     = s1_prod_reg[31:16];
    assign rem    = s1_mag_reg - (22'(q0) * 22'(isfd_pkg::TEMP_DIV));
    assign quot   = q0 + 16'(rem >= 22'(isfd_pkg::TEMP_DIV));
    assign quot_s = $signed({1'b0, quot});
    assign temp   = (s1_neg_reg ? -quot_s : quot_s) + isfd_pkg::TEMP_OFFSET;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= q_valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_kind_reg <= q_data.kind;
            s1_x_reg    <= prod_x[22:0];
            s1_y_reg    <= prod_y[22:0];
            s1_z_reg    <= prod_z[22:0];
            s1_neg_reg  <= q_data.raw_t[15];
            s1_mag_reg  <= t_mag;
            s1_prod_reg <= t_prod;
        end
        if (out_adv && s1_valid_reg)
        begin
            out_reg.frame_kind  <= s1_kind_reg;
            out_reg.value_x     <= s1_x_reg;
            out_reg.value_y     <= s1_y_reg;
            out_reg.value_z     <= s1_z_reg;
            out_reg.temperature <= temp;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.frame_kind != isfd_pkg::KIND_NONE)
        else $error("Result carries an unknown frame kind.");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> rem < 22'(2 * 85))
        else $error("Temperature reciprocal estimate is off by more than one.");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_adv |=> s1_valid_reg)
        else $error("Scaling stage lost a frame under output stall.");

endmodule

`default_nettype wire

>>> rtl/imu_serial_frame_decoder.sv
// Top level of the IMU serial frame decoder: byte stream in, scaled frame results out.
// Result path: frame queue, scaling stage register, then output register.
// Throughput: one byte beat per cycle; tready falls only while the frame queue is full.
// Result rate: the two-stage back end takes one frame per cycle while the output is not stalled.
// Reset: asynchronous, active low; clears the frame position, the queue and all valid flags,
// and restores the sync byte to 0x55.
`timescale 1ns / 1ps
`default_nettype none

module imu_serial_frame_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,     // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata,     // [1:0] frame_kind, [24:2] value_x,
                                               // [47:25] value_y, [70:48] value_z,
                                               // [87:71] temperature
    input  wire logic        sync_byte_we,
    input  wire logic [7:0]  sync_byte_wdata
);

    logic               push_valid;
    isfd_pkg::frame_t   push_data;
    logic               queue_full;
    logic               q_pop;
    logic               q_valid;
    isfd_pkg::frame_t   q_data;
    isfd_pkg::result_t  result;

    isfd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .in_byte         (s_axis_tdata),
        .sync_byte_we    (sync_byte_we),
        .sync_byte_wdata (sync_byte_wdata),
        .queue_full      (queue_full),
        .push_valid      (push_valid),
        .push_data       (push_data)
    );

    isfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    isfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (result)
    );

    assign m_axis_tdata = result;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the IMU serial frame decoder: random byte streams against a predictor.
`timescale 1ns / 1ps

module tb_top;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic        sync_byte_we = 1'b0;
    logic [7:0]  sync_byte_wdata = '0;

    logic [7:0]          rx_bytes[$];
    isfd_pkg::result_t   frames_due[$];
    logic [7:0]          frame_buf[11];
    logic [7:0]          held_bytes[$];

    logic [7:0] dec_sync = isfd_pkg::SYNC_RESET;
    logic [3:0] dec_pos = isfd_pkg::POS_SYNC;
    logic [7:0] dec_store[isfd_pkg::STORE_DEPTH];

    int send_idle_pct = 8;
    int recv_idle_pct = 45;
    bit stall_req = 1'b0;
    bit stall_seen = 1'b0;
    int stall_left = 0;
    int fail_count = 0;

    imu_serial_frame_decoder uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),     // [7:0] rx_byte
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),     // [1:0] frame_kind, [24:2] value_x, [47:25] value_y,
                                            // [70:48] value_z, [87:71] temperature
        .sync_byte_we   (sync_byte_we),
        .sync_byte_wdata(sync_byte_wdata)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic bit decode_byte(input logic [7:0] b, output isfd_pkg::result_t res);
        int mul;
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic signed [15:0] raw_z;
        logic signed [15:0] raw_t;
        res = '0;
        if (dec_pos == isfd_pkg::POS_SYNC || dec_pos > isfd_pkg::POS_CHECK)
        begin
            dec_pos = (b == dec_sync) ? isfd_pkg::POS_FIRST : isfd_pkg::POS_SYNC;
            return 1'b0;
        end
        if (dec_pos < isfd_pkg::POS_CHECK)
        begin
            dec_store[dec_pos - isfd_pkg::POS_FIRST] = b;
            dec_pos = dec_pos + 4'd1;
            return 1'b0;
        end
        dec_pos = isfd_pkg::POS_SYNC;
        case (dec_store[0])
            isfd_pkg::TYPE_ACCEL:
            begin
                res.frame_kind = isfd_pkg::KIND_ACCEL;
                mul = int'(isfd_pkg::MUL_ACCEL);
            end
            isfd_pkg::TYPE_RATE:
            begin
                res.frame_kind = isfd_pkg::KIND_RATE;
                mul = int'(isfd_pkg::MUL_RATE);
            end
            isfd_pkg::TYPE_ANGLE:
            begin
                res.frame_kind = isfd_pkg::KIND_ANGLE;
                mul = int'(isfd_pkg::MUL_ANGLE);
            end
            default:
            begin
                return 1'b0;
            end
        endcase
        raw_x = {dec_store[2], dec_store[1]};
        raw_y = {dec_store[4], dec_store[3]};
        raw_z = {dec_store[6], dec_store[5]};
        raw_t = {dec_store[8], dec_store[7]};
        res.value_x = 23'(int'(raw_x) * mul);
        res.value_y = 23'(int'(raw_y) * mul);
        res.value_z = 23'(int'(raw_z) * mul);
        res.temperature = 17'((int'(raw_t) * 64) / 85 + int'(isfd_pkg::TEMP_OFFSET));
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        isfd_pkg::result_t res;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (decode_byte(s_axis_tdata, res))
                begin
                    frames_due.push_back(res);
                end
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (rx_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= rx_bytes.pop_front();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        isfd_pkg::result_t got;
        isfd_pkg::result_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (frames_due.size() == 0)
                begin
                    report_mismatch("unexpected result, kind", int'(got.frame_kind), -1);
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (got.frame_kind != want.frame_kind)
                        report_mismatch("frame_kind", int'(got.frame_kind),
                                        int'(want.frame_kind));
                    if (got.value_x != want.value_x)
                        report_mismatch("value_x", int'(got.value_x), int'(want.value_x));
                    if (got.value_y != want.value_y)
                        report_mismatch("value_y", int'(got.value_y), int'(want.value_y));
                    if (got.value_z != want.value_z)
                        report_mismatch("value_z", int'(got.value_z), int'(want.value_z));
                    if (got.temperature != want.temperature)
                        report_mismatch("temperature", int'(got.temperature),
                                        int'(want.temperature));
                end
            end
            if (stall_req != stall_seen)
            begin
                stall_seen = stall_req;
                stall_left = 300;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic make_frame(input logic [7:0] sync, input logic [7:0] kind_code,
                              input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z, input logic [15:0] t);
        frame_buf[0]  = sync;
        frame_buf[1]  = kind_code;
        frame_buf[2]  = x[7:0];
        frame_buf[3]  = x[15:8];
        frame_buf[4]  = y[7:0];
        frame_buf[5]  = y[15:8];
        frame_buf[6]  = z[7:0];
        frame_buf[7]  = z[15:8];
        frame_buf[8]  = t[7:0];
        frame_buf[9]  = t[15:8];
        frame_buf[10] = 8'($urandom);
    endtask

    task automatic send_bytes(input int first, input int last);
        for (int i = first; i <= last; i++)
        begin
            rx_bytes.push_back(frame_buf[i]);
        end
    endtask

    task automatic wait_idle();
        while (rx_bytes.size() > 0 || s_axis_tvalid || frames_due.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic write_sync(input logic [7:0] value);
        @(posedge clk);
        sync_byte_we    <= 1'b1;
        sync_byte_wdata <= value;
        dec_sync = value;
        @(posedge clk);
        sync_byte_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] sync_plan[6];
        logic [7:0] kind_code;
        int count;
        int roll;
        int cut;
        int n;
        sync_plan = '{8'h00, 8'hFF, 8'($urandom), 8'hA5, 8'($urandom), isfd_pkg::SYNC_RESET};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        rx_bytes.push_back(8'h00);
        make_frame(isfd_pkg::SYNC_RESET, isfd_pkg::TYPE_ACCEL, 16'h8000, 16'h7FFF, 16'h0000,
                   16'h8000);
        send_bytes(0, 10);
        make_frame(isfd_pkg::SYNC_RESET, isfd_pkg::TYPE_RATE, 16'h5555, 16'h8000, 16'hFFFF,
                   16'h7FFF);
        send_bytes(0, 10);
        wait_idle();

        for (int phase = 0; phase < 6; phase++)
        begin
            send_idle_pct = (phase < 2) ? 8 : (phase < 4) ? 45 : 0;
            recv_idle_pct = (phase < 2) ? 45 : (phase < 4) ? 8 : 0;
            write_sync(sync_plan[phase]);
            // The frame begun before the register write must still complete.
            while (held_bytes.size() > 0)
            begin
                rx_bytes.push_back(held_bytes.pop_front());
            end
            if (phase == 1)
            begin
                stall_req = ~stall_req;
            end
            count = 0;
            while (count < 225)
            begin
                roll = $urandom_range(99);
                if (roll < 10)
                begin
                    n = $urandom_range(1, 3);
                    repeat (n) rx_bytes.push_back(8'($urandom));
                    count += n;
                end
                case ($urandom_range(9))
                    0, 1, 2: kind_code = isfd_pkg::TYPE_ACCEL;
                    3, 4, 5: kind_code = isfd_pkg::TYPE_RATE;
                    6, 7, 8: kind_code = isfd_pkg::TYPE_ANGLE;
                    default: kind_code = 8'($urandom);
                endcase
                make_frame(sync_plan[phase], kind_code, pick_word(), pick_word(),
                           pick_word(), pick_word());
                cut = (roll >= 94) ? $urandom_range(1, 10) : 11;
                send_bytes(0, cut - 1);
                count += cut;
            end
            if (phase < 5)
            begin
                make_frame(sync_plan[phase], isfd_pkg::TYPE_ANGLE, pick_word(), pick_word(),
                           pick_word(), pick_word());
                send_bytes(0, 4);
                for (int i = 5; i < 11; i++)
                begin
                    held_bytes.push_back(frame_buf[i]);
                end
            end
            wait_idle();
        end

        repeat (10) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial
    begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
rtl/isfd_pkg.sv
rtl/isfd_front.sv
rtl/isfd_queue.sv
rtl/isfd_back.sv
rtl/imu_serial_frame_decoder.sv
tb/tb_top.sv
